@@ hdl/peak_count_pitch_estimator_defines.svh @@
// Assertion macros for the peak counting pitch estimator.
// Used by the tracker and the result unit; needs clk and arst_n in scope.
`ifndef PEAK_COUNT_PITCH_ESTIMATOR_DEFINES_SVH
`define PEAK_COUNT_PITCH_ESTIMATOR_DEFINES_SVH

`ifndef SYNTH
// Condition checked at every clock edge out of reset.
`define PCPE_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("pcpe assertion failed");
// Antecedent in this cycle implies consequent in the next one.
`define PCPE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcpe assertion failed");
`else
`define PCPE_ASSERT(lbl, cond)
`define PCPE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/pcpe_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, types and helpers of the peak counting pitch estimator.
// No dependencies.
package pcpe_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int INDEX_BITS  = 24;
	localparam int RATE_BITS   = 18;
	localparam int FREQ_BITS   = 25;
	localparam int COUNT_BITS  = 24;
	localparam int FRAC_BITS   = 8;

	localparam int PROD_BITS = RATE_BITS + INDEX_BITS;
	localparam int NUM_BITS  = PROD_BITS + FRAC_BITS;
	localparam int STEP_BITS = $clog2(NUM_BITS + 1);

	localparam logic [RATE_BITS-1:0]  RATE_RESET = RATE_BITS'(44100);
	localparam logic [INDEX_BITS-1:0] IDX_MAX    = '1;
	localparam logic [FREQ_BITS-1:0]  FREQ_MAX   = '1;
	localparam logic [63:0]           COUNT_MAX  = (64'd1 << COUNT_BITS) - 64'd1;

	typedef logic [INDEX_BITS-1:0]         index_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [RATE_BITS-1:0]          rate_t;

	// Peak record of one finished sample record.
	typedef struct packed {
		index_t peaks;
		index_t first;
		index_t last;
	} record_t;

	function automatic logic [COUNT_BITS-1:0] count_sat(input index_t peaks);
		logic [63:0] wide;
		wide = 64'(peaks);
		if (wide > COUNT_MAX)
			wide = COUNT_MAX;
		return COUNT_BITS'(wide);
	endfunction

endpackage

@@ hdl/peak_count_pitch_estimator.sv @@
`timescale 1ns / 1ps
// Top level of the peak counting pitch estimator.
// Depends on pcpe_pkg, pcpe_track and pcpe_calc.
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  sample, last_sample
//   out      from block out_valid / out_stall frequency_q8, peak_count, valid_res
//   cfg      to block   cfg_valid / cfg_ready cfg_data (sample_rate)
//
// A sample without the last flag starts nothing, and the next can follow at once.
// A last sample starts the result unit: a multiply state, then the restoring
// divider with one quotient bit per cycle (NUM_BITS = 50), then a load of the
// output register; in_stall is high through these states. A record with fewer
// than two distinct peaks skips straight to the load state.
// The load state waits while an earlier result is stalled in the output register.
// A stalled result waits in the output register while new samples are taken.
// Reset clears the record and sets the sample rate to 44100 Hz.
module peak_count_pitch_estimator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [pcpe_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                            last_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pcpe_pkg::FREQ_BITS-1:0]  frequency_q8,
	output logic [pcpe_pkg::COUNT_BITS-1:0] peak_count,
	output logic                            valid_res,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pcpe_pkg::RATE_BITS-1:0]  cfg_data
);
	import pcpe_pkg::*;

	rate_t   rate_q;
	logic    busy;
	logic    in_xfer;
	record_t rec_next;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;
	assign in_xfer   = in_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rate_q <= cfg_data;
		end
	end

	pcpe_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (in_xfer),
		.sample      (sample),
		.last_sample (last_sample),
		.rec_next    (rec_next)
	);

	pcpe_calc u_calc (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_xfer && last_sample),
		.rec          (rec_next),
		.rate         (rate_q),
		.out_stall    (out_stall),
		.busy         (busy),
		.out_valid    (out_valid),
		.frequency_q8 (frequency_q8),
		.peak_count   (peak_count),
		.valid_res    (valid_res)
	);

endmodule

@@ hdl/pcpe_track.sv @@
`timescale 1ns / 1ps
// Peak tracker: previous sample, rise flag, sample index and peak record.
// Depends on pcpe_pkg and the assertion macro header.
`include "peak_count_pitch_estimator_defines.svh"

module pcpe_track (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  pcpe_pkg::sample_t sample,
	input  logic             last_sample,
	output pcpe_pkg::record_t rec_next
);
	import pcpe_pkg::*;

	sample_t prev_q;
	logic    have_prev_q;
	logic    rising_q;
	index_t  index_q;
	index_t  first_q;
	index_t  last_idx_q;
	index_t  peaks_q;

	logic   rise;
	logic   peak;
	logic   rising_n;
	index_t at;
	index_t peaks_n;
	index_t first_n;
	index_t last_n;

	always_comb begin
		rise = have_prev_q && (sample > prev_q);
		peak = have_prev_q && !rise && rising_q;
		at   = index_q - index_t'(1);
		peaks_n = (peak && peaks_q != IDX_MAX) ? peaks_q + index_t'(1) : peaks_q;
		first_n = (peak && peaks_q == '0) ? at : first_q;
		last_n  = peak ? at : last_idx_q;
		if (rise)
			rising_n = 1'b1;
		else if (peak)
			rising_n = 1'b0;
		else
			rising_n = rising_q;
		rec_next = '{peaks: peaks_n, first: first_n, last: last_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			rising_q    <= 1'b0;
			index_q     <= '0;
			first_q     <= '0;
			last_idx_q  <= '0;
			peaks_q     <= '0;
		end else if (take) begin
			if (last_sample) begin
				// record handed to the result unit: start over
				prev_q      <= '0;
				have_prev_q <= 1'b0;
				rising_q    <= 1'b0;
				index_q     <= '0;
				first_q     <= '0;
				last_idx_q  <= '0;
				peaks_q     <= '0;
			end else begin
				prev_q      <= sample;
				have_prev_q <= 1'b1;
				rising_q    <= rising_n;
				if (index_q != IDX_MAX)
					index_q <= index_q + index_t'(1);
				first_q     <= first_n;
				last_idx_q  <= last_n;
				peaks_q     <= peaks_n;
			end
		end
	end

	`PCPE_ASSERT(a_no_peak_no_index, (peaks_q != '0) || (first_q == '0 && last_idx_q == '0))
	`PCPE_ASSERT(a_peak_order, (peaks_q == '0) || (last_idx_q >= first_q))
	`PCPE_ASSERT(a_rise_needs_prev, have_prev_q || !rising_q)

endmodule

@@ hdl/pcpe_calc.sv @@
`timescale 1ns / 1ps
// Result unit: one multiply, then restoring division with one shared
// subtractor a bit per cycle, saturation and the output register.
// Depends on pcpe_pkg and the assertion macro header.
`include "peak_count_pitch_estimator_defines.svh"

module pcpe_calc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  pcpe_pkg::record_t             rec,
	input  pcpe_pkg::rate_t               rate,
	input  logic                          out_stall,
	output logic                          busy,
	output logic                          out_valid,
	output logic [pcpe_pkg::FREQ_BITS-1:0]  frequency_q8,
	output logic [pcpe_pkg::COUNT_BITS-1:0] peak_count,
	output logic                          valid_res
);
	import pcpe_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic                    ok_q;
	index_t                  span_q;
	index_t                  cnt1_q;
	logic [COUNT_BITS-1:0]   count_q;
	logic [NUM_BITS-1:0]     num_q;
	logic [INDEX_BITS-1:0]   rem_q;
	logic [STEP_BITS-1:0]    step_q;
	logic                    out_valid_q;
	logic [FREQ_BITS-1:0]    freq_q;
	logic [COUNT_BITS-1:0]   peak_count_q;
	logic                    valid_res_q;

	logic [INDEX_BITS:0]     rem_sh;
	logic [INDEX_BITS+1:0]   diff;
	logic                    qbit;
	logic [PROD_BITS-1:0]    prod;
	logic [FREQ_BITS-1:0]    freq_sat;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_BITS-1]};
		diff   = {1'b0, rem_sh} - {2'b00, span_q};
		qbit   = !diff[INDEX_BITS+1];
		prod   = PROD_BITS'(rate) * PROD_BITS'(cnt1_q);
		if (!ok_q)
			freq_sat = '0;
		else if (|num_q[NUM_BITS-1:FREQ_BITS])
			freq_sat = FREQ_MAX;
		else
			freq_sat = num_q[FREQ_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ok_q         <= 1'b0;
			span_q       <= '0;
			cnt1_q       <= '0;
			count_q      <= '0;
			num_q        <= '0;
			rem_q        <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			freq_q       <= '0;
			peak_count_q <= '0;
			valid_res_q  <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						ok_q    <= (rec.peaks >= index_t'(2)) && (rec.last > rec.first);
						span_q  <= rec.last - rec.first;
						cnt1_q  <= rec.peaks - index_t'(1);
						count_q <= count_sat(rec.peaks);
						num_q   <= '0;
						if ((rec.peaks >= index_t'(2)) && (rec.last > rec.first))
							state_q <= ST_MUL;
						else
							state_q <= ST_DONE;
					end
				end
				ST_MUL: begin
					num_q   <= {prod, FRAC_BITS'(0)};
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// shift in one numerator bit, keep the difference when it fits
					num_q  <= {num_q[NUM_BITS-2:0], qbit};
					rem_q  <= qbit ? diff[INDEX_BITS-1:0] : rem_sh[INDEX_BITS-1:0];
					step_q <= step_q + STEP_BITS'(1);
					if (step_q == STEP_BITS'(NUM_BITS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						freq_q       <= freq_sat;
						peak_count_q <= count_q;
						valid_res_q  <= ok_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign frequency_q8 = freq_q;
	assign peak_count   = peak_count_q;
	assign valid_res    = valid_res_q;

	`PCPE_ASSERT(a_rem_below_span, (state_q != ST_DIV) || (rem_q < span_q))
	`PCPE_ASSERT(a_step_bound, (state_q != ST_DIV) || (step_q < STEP_BITS'(NUM_BITS)))
	`PCPE_ASSERT(a_invalid_zero, !out_valid_q || valid_res_q || (freq_q == '0))
	`PCPE_ASSERT_NEXT(a_result_once, (state_q == ST_DONE) && (!out_valid_q || !out_stall),
		out_valid_q && (state_q == ST_IDLE))

endmodule

@@ verif/peak_count_pitch_estimator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the peak counting pitch estimator: directed records,
// sample rate sweeps and random waveform records. Needs pcpe_pkg and the RTL.
module peak_count_pitch_estimator_tb;
	import pcpe_pkg::*;

	localparam int RANDOM_SAMPLES = 420;
	localparam int MIN_RECORDS    = 20;
	localparam int SETTLE_CYCLES  = 60;
	localparam int IDLE_LIMIT     = 4000;
	localparam int REPORT_LIMIT   = 10;
	localparam int SMP_HI         = 2 ** (SAMPLE_BITS - 1) - 1;
	localparam int SMP_LO         = -(2 ** (SAMPLE_BITS - 1));
	localparam rate_t RATE_TOP    = '1;

	typedef struct packed {
		logic [FREQ_BITS-1:0]  freq;
		logic [COUNT_BITS-1:0] count;
		logic                  ok;
	} pitch_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sample_t in_sample = '0;
	logic in_last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FREQ_BITS-1:0] frequency_q8;
	logic [COUNT_BITS-1:0] peak_count;
	logic valid_res;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	rate_t cfg_data = '0;

	// Peak tracker state mirrored on the testbench side.
	rate_t   rate_hz = RATE_RESET;
	sample_t prev_smp;
	bit      have_prev;
	bit      climbing;
	index_t  next_index;
	index_t  first_peak;
	index_t  last_peak;
	index_t  peaks_found;
	pitch_t  pending_pitch[$];

	int gap_max = 15;
	int stall_max = 15;
	int samples_sent = 0;
	int records_sent = 0;
	int rate_writes = 0;
	int results_seen = 0;
	int mismatches = 0;
	int stalls_drawn = 0;
	int out_stall_left = 0;
	int quiet_cycles = 0;
	int script[$];

	always #5 clk = ~clk;

	function automatic void clear_record();
		prev_smp = '0;
		have_prev = 1'b0;
		climbing = 1'b0;
		next_index = '0;
		first_peak = '0;
		last_peak = '0;
		peaks_found = '0;
	endfunction

	// Advance the peak tracker by one sample; queue the pitch on the last one.
	function automatic void track_sample(input sample_t s, input logic last);
		pitch_t res;
		logic [63:0] num;
		logic [63:0] quo;
		if (have_prev) begin
			if (s > prev_smp) begin
				climbing = 1'b1;
			end else if (climbing) begin
				// the previous sample was the top of the rise
				if (peaks_found == '0)
					first_peak = next_index - 1'b1;
				last_peak = next_index - 1'b1;
				if (peaks_found != IDX_MAX)
					peaks_found = peaks_found + 1'b1;
				climbing = 1'b0;
			end
		end
		prev_smp = s;
		have_prev = 1'b1;
		if (next_index != IDX_MAX)
			next_index = next_index + 1'b1;
		if (last) begin
			res = '0;
			res.count = COUNT_BITS'(peaks_found);
			if (peaks_found >= 2 && last_peak > first_peak) begin
				num = (64'(rate_hz) * 64'(peaks_found - 1'b1)) << FRAC_BITS;
				quo = num / 64'(last_peak - first_peak);
				res.freq = (quo > 64'(FREQ_MAX)) ? FREQ_MAX : FREQ_BITS'(quo);
				res.ok = 1'b1;
			end
			pending_pitch.push_back(res);
			clear_record();
		end
	endfunction

	task automatic send_sample(input sample_t s, input logic last);
		int gap;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_sample <= s;
		in_last <= last;
		do @(posedge clk); while (in_stall !== 1'b0);
		track_sample(s, last);
		samples_sent++;
		if (last)
			records_sent++;
	endtask

	// Drop valid, wait for every pending result, then let the result unit settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pitch.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input rate_t r);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		rate_hz = r;
		rate_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic play_script();
		foreach (script[i])
			send_sample(sample_t'(script[i]), i == script.size() - 1);
		script.delete();
	endtask

	// Triangle wave with optional noise, clipped to the sample range.
	task automatic send_wave(input int len, input int period, input int amp, input int base,
			input int noise);
		int off;
		int half;
		int ph;
		int v;
		off = $urandom_range(0, period - 1);
		half = period / 2;
		for (int k = 0; k < len; k++) begin
			ph = (k + off) % period;
			if (ph < half)
				v = base - amp + (2 * amp * ph) / half;
			else
				v = base + amp - (2 * amp * (ph - half)) / (period - half);
			if (noise > 0)
				v += int'($urandom_range(0, 2 * noise)) - noise;
			if (v > SMP_HI)
				v = SMP_HI;
			if (v < SMP_LO)
				v = SMP_LO;
			send_sample(sample_t'(v), k == len - 1);
		end
	endtask

	task automatic send_noise(input int len);
		for (int k = 0; k < len; k++)
			send_sample(sample_t'($urandom), k == len - 1);
	endtask

	task automatic test_directed();
		script = '{SMP_HI};
		play_script();
		// falling only: no peak
		script = '{100, 50, 0, SMP_LO};
		play_script();
		// a rise into the end of the record is not a peak
		script = '{SMP_LO, SMP_HI};
		play_script();
		// plateaus after a rise peak on their first sample
		script = '{0, 10, 10, 5, 20, 20, 20, 3, 4};
		play_script();
		script = '{SMP_LO, SMP_HI, SMP_LO, SMP_HI, SMP_LO, SMP_HI};
		play_script();
	endtask

	task automatic test_rate_settings();
		rate_t rates[6];
		rates = '{rate_t'(8000), rate_t'(192000), rate_t'(0), RATE_TOP, rate_t'(1),
			RATE_RESET};
		foreach (rates[i]) begin
			write_rate(rates[i]);
			// tightest peak spacing gives the highest frequency
			send_wave(12, 2, SMP_HI, 0, 0);
			send_wave(20, $urandom_range(3, 12), $urandom_range(1, 16000), 0, 0);
		end
	endtask

	task automatic test_random_records();
		int first_sample;
		int first_record;
		int len;
		int amp;
		int pick;
		first_sample = samples_sent;
		first_record = records_sent;
		while (samples_sent - first_sample < RANDOM_SAMPLES
				|| records_sent - first_record < MIN_RECORDS) begin
			if ((records_sent - first_record) % 8 == 0) begin
				if ($urandom_range(0, 3) == 0)
					write_rate(rate_t'($urandom));
				else
					write_rate(rate_t'($urandom_range(8000, 192000)));
				gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
				stall_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
			end
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = 1;
			else if (pick == 1)
				len = $urandom_range(60, 150);
			else
				len = $urandom_range(2, 28);
			if ($urandom_range(0, 4) == 0) begin
				send_noise(len);
			end else begin
				amp = $urandom_range(0, 16000);
				send_wave(len, $urandom_range(2, 24), amp, int'($urandom_range(0, 32000)) - 16000,
					($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, amp / 4));
			end
		end
	endtask

	peak_count_pitch_estimator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(in_sample),
		.last_sample(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frequency_q8(frequency_q8),
		.peak_count(peak_count),
		.valid_res(valid_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always @(posedge clk) begin : check_results
		pitch_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (pending_pitch.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: freq %0d count %0d valid %0b",
						frequency_q8, peak_count, valid_res);
			end else begin
				want = pending_pitch.pop_front();
				if (frequency_q8 !== want.freq || peak_count !== want.count
						|| valid_res !== want.ok) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result %0d: expected freq %0d count %0d valid %0b, got %0d %0d %0b",
							results_seen, want.freq, want.count, want.ok,
							frequency_q8, peak_count, valid_res);
				end
			end
		end
	end

	// Draw a fresh stall after each result transfer; count it down while a result waits.
	always @(negedge clk) begin
		if (stalls_drawn != results_seen) begin
			out_stall_left = $urandom_range(0, stall_max);
			stalls_drawn = results_seen;
		end
		out_stall <= (out_stall_left > 0);
		if (out_valid === 1'b1 && out_stall_left > 0)
			out_stall_left--;
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
				|| (cfg_valid && cfg_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("peak_count_pitch_estimator regression: fail");
			$finish;
		end
	end

	initial begin
		clear_record();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_rate_settings();
		test_random_records();
		drain();
		$display("%0d samples in %0d records over %0d rate writes", samples_sent, records_sent,
			rate_writes);
		$display("%0d pitch results compared, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("peak_count_pitch_estimator regression: pass");
		else
			$display("peak_count_pitch_estimator regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/pcpe_pkg.sv
hdl/pcpe_track.sv
hdl/pcpe_calc.sv
hdl/peak_count_pitch_estimator.sv
verif/peak_count_pitch_estimator_tb.sv
